### rtl/pcr_pkg.sv
// Package for the controller pak command responder: constants, shared types
// and the CRC-8 helper functions. No dependencies.
package pcr_pkg;

  // Data bytes carried by one pak transfer
  localparam int unsigned DATA_BYTES = 32;

  // Frame positions
  localparam int unsigned POS_W          = 6;
  localparam logic [POS_W-1:0] POS_CMD   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ADDR_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_ADDR_LO = POS_W'(4);
  localparam logic [POS_W-1:0] FIRST_DATA_POS = POS_W'(5);
  localparam logic [POS_W-1:0] END_POS   = POS_W'(4 + DATA_BYTES);

  // Width of the remaining-results counter of a read burst
  localparam int unsigned REM_W = $clog2(DATA_BYTES + 1);

  // Command codes
  localparam logic [7:0] CMD_READ  = 8'h02;
  localparam logic [7:0] CMD_WRITE = 8'h03;

  // CRC and address constants
  localparam logic [7:0]  CRC_POLY    = 8'h85;
  localparam logic [7:0]  ADDR_MASK   = 8'hE0;
  localparam logic [15:0] FILL_LOW    = 16'h8000;
  localparam logic [15:0] FILL_HIGH   = 16'h9000;
  localparam logic [15:0] RUMBLE_ADDR = 16'hC000;
  localparam logic [7:0]  FILL_BYTE   = 8'h80;
  localparam logic [7:0]  ZERO_BYTE   = 8'h00;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RAW_PAK_PORTS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RUMBLE_AVAILABLE = 1'b1;

  // Configuration register contents
  typedef struct packed {
    logic [3:0] raw_pak_ports;
    logic       rumble_available;
  } pcr_cfg_t;

  // Reply request from the frame parser to the reply generator
  typedef struct packed {
    logic       rd;     // start a read burst
    logic       wr;     // single write CRC reply
    logic [1:0] port;
    logic [7:0] fill;
    logic [7:0] crc;
    logic       upd;
    logic       on;
  } pcr_evt_t;

  // One byte through the CRC-8, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC of a full block of one repeated byte
  function automatic logic [7:0] block_crc(input logic [7:0] b);
    logic [7:0] c;
    c = 8'h00;
    for (int k = 0; k < DATA_BYTES; k++) begin
      c = crc8_update(c, b);
    end
    return c;
  endfunction

  localparam logic [7:0] FILL_CRC = block_crc(FILL_BYTE);
  localparam logic [7:0] ZERO_CRC = block_crc(ZERO_BYTE);

endpackage

### rtl/pcr_if.sv
// Channel interfaces of the pak command responder: input bytes, replies and
// configuration writes. Depends on pcr_pkg.
interface pcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] port;
  logic [7:0] frame_byte;
  logic       frame_start;

  modport source (output valid, output port, output frame_byte, output frame_start,
                  input ready);
  modport sink   (input valid, input port, input frame_byte, input frame_start,
                  output ready);
endinterface

interface pcr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply_port;
  logic [7:0] reply_byte;
  logic       last;
  logic       rumble_update;
  logic       rumble_on;

  modport source (output valid, output reply_port, output reply_byte, output last,
                  output rumble_update, output rumble_on, input ready);
  modport sink   (input valid, input reply_port, input reply_byte, input last,
                  input rumble_update, input rumble_on, output ready);
endinterface

interface pcr_cfg_if;
  import pcr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/pcr_cfg_regs.sv
// Configuration registers of the pak command responder.
// Depends on pcr_pkg and pcr_cfg_if.
module pcr_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  pcr_cfg_if.sink          cfg_ch,
  output pcr_pkg::pcr_cfg_t cfg
);
  import pcr_pkg::*;

  logic [3:0] raw_r;
  logic       rumble_r;

  // Always accept a write
  assign cfg_ch.ready = 1'b1;

  // Capture a write transaction into the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 4'h0;
      rumble_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_RAW_PAK_PORTS:    raw_r    <= cfg_ch.data[3:0];
        REG_RUMBLE_AVAILABLE: rumble_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign cfg.raw_pak_ports    = raw_r;
  assign cfg.rumble_available = rumble_r;

endmodule

### rtl/pcr_frame_parser.sv
// Frame parser: tracks the frame position, command, address and running CRC
// and raises reply requests. Depends on pcr_pkg and pcr_in_if.
module pcr_frame_parser (
  input  logic              clk,
  input  logic              rst_n,
  pcr_in_if.sink            in_ch,
  input  logic              take_ok,
  input  pcr_pkg::pcr_cfg_t cfg,
  output pcr_pkg::pcr_evt_t evt
);
  import pcr_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             active_r, active_nxt;
  logic [1:0]       port_r, port_nxt;
  logic [7:0]       cmd_r, cmd_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic             nz_r, nz_nxt;

  logic             accept;
  logic [POS_W-1:0] pos_e;
  logic             active_e;
  logic [7:0]       cmd_e;
  logic [15:0]      addr_e;
  logic [7:0]       crc_e;
  logic             nz_e;
  logic             raw;
  logic             in_fill;

  assign in_ch.ready = take_ok;
  assign accept      = in_ch.valid && take_ok;

  // Work out the next frame state and any reply for this byte
  always_comb begin
    // A frame start drops whatever frame was open
    active_e = in_ch.frame_start || active_r;
    pos_e    = in_ch.frame_start ? '0 : pos_r;
    port_nxt = in_ch.frame_start ? in_ch.port : port_r;
    cmd_e    = in_ch.frame_start ? 8'h00 : cmd_r;
    addr_e   = in_ch.frame_start ? 16'h0000 : addr_r;
    crc_e    = in_ch.frame_start ? 8'h00 : crc_r;
    nz_e     = in_ch.frame_start ? 1'b0 : nz_r;

    active_nxt = active_e;
    pos_nxt    = pos_e;
    cmd_nxt    = cmd_e;
    addr_nxt   = addr_e;
    crc_nxt    = crc_e;
    nz_nxt     = nz_e;
    raw        = cfg.raw_pak_ports[port_nxt];
    in_fill    = 1'b0;

    evt      = '0;
    evt.port = port_nxt;

    if (active_e && (pos_e <= END_POS)) begin
      pos_nxt = pos_e + 1'b1;
      if (pos_e == POS_CMD) begin
        cmd_nxt = in_ch.frame_byte;
      end else if (pos_e == POS_ADDR_HI) begin
        addr_nxt = {in_ch.frame_byte, addr_e[7:0]};
      end else if (pos_e == POS_ADDR_LO) begin
        addr_nxt = {addr_e[15:8], in_ch.frame_byte & ADDR_MASK};
        in_fill  = (addr_nxt >= FILL_LOW) && (addr_nxt < FILL_HIGH);
        evt.rd   = (cmd_e == CMD_READ) && raw;
        evt.fill = in_fill ? FILL_BYTE : ZERO_BYTE;
        evt.crc  = in_fill ? FILL_CRC : ZERO_CRC;
      end else if (pos_e >= FIRST_DATA_POS) begin
        crc_nxt = crc8_update(crc_e, in_ch.frame_byte);
        if (pos_e == FIRST_DATA_POS) begin
          nz_nxt = (in_ch.frame_byte != 8'h00);
        end
        evt.wr  = (pos_e == END_POS) && (cmd_e == CMD_WRITE) && raw;
        evt.crc = crc_nxt;
        evt.upd = (addr_e == RUMBLE_ADDR) && cfg.rumble_available;
        evt.on  = evt.upd && nz_nxt;
      end
    end

    // Only an accepted byte raises a reply
    if (!accept) begin
      evt.rd = 1'b0;
      evt.wr = 1'b0;
    end
  end

  // Commit the frame state on an accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      active_r <= 1'b0;
      port_r   <= 2'd0;
      cmd_r    <= 8'h00;
      addr_r   <= 16'h0000;
      crc_r    <= 8'h00;
      nz_r     <= 1'b0;
    end else if (accept) begin
      pos_r    <= pos_nxt;
      active_r <= active_nxt;
      port_r   <= port_nxt;
      cmd_r    <= cmd_nxt;
      addr_r   <= addr_nxt;
      crc_r    <= crc_nxt;
      nz_r     <= nz_nxt;
    end
  end

endmodule

### rtl/pcr_reply_gen.sv
// Reply generator: output register plus the read-burst counter that streams
// fill bytes and their CRC. Depends on pcr_pkg and pcr_out_if.
module pcr_reply_gen (
  input  logic              clk,
  input  logic              rst_n,
  input  pcr_pkg::pcr_evt_t evt,
  output logic              take_ok,
  pcr_out_if.source         out_ch
);
  import pcr_pkg::*;

  logic             valid_r, valid_nxt;
  logic [1:0]       port_r, port_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             upd_r, upd_nxt;
  logic             on_r, on_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [7:0]       bfill_r, bfill_nxt;
  logic [7:0]       bcrc_r, bcrc_nxt;
  logic             load;

  // The output register can take a new result when empty or being drained
  assign load    = !valid_r || out_ch.ready;
  assign take_ok = load && (rem_r == '0);

  // Choose the next result: burst continuation first, then a new request
  always_comb begin
    valid_nxt = valid_r;
    port_nxt  = port_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    upd_nxt   = upd_r;
    on_nxt    = on_r;
    rem_nxt   = rem_r;
    bfill_nxt = bfill_r;
    bcrc_nxt  = bcrc_r;
    if (load) begin
      valid_nxt = 1'b0;
      if (rem_r != '0) begin
        valid_nxt = 1'b1;
        upd_nxt   = 1'b0;
        on_nxt    = 1'b0;
        rem_nxt   = rem_r - 1'b1;
        if (rem_r == REM_W'(1)) begin
          byte_nxt = bcrc_r;
          last_nxt = 1'b1;
        end else begin
          byte_nxt = bfill_r;
          last_nxt = 1'b0;
        end
      end else if (evt.rd) begin
        valid_nxt = 1'b1;
        port_nxt  = evt.port;
        byte_nxt  = evt.fill;
        last_nxt  = 1'b0;
        upd_nxt   = 1'b0;
        on_nxt    = 1'b0;
        rem_nxt   = REM_W'(DATA_BYTES);
        bfill_nxt = evt.fill;
        bcrc_nxt  = evt.crc;
      end else if (evt.wr) begin
        valid_nxt = 1'b1;
        port_nxt  = evt.port;
        byte_nxt  = evt.crc;
        last_nxt  = 1'b1;
        upd_nxt   = evt.upd;
        on_nxt    = evt.on;
      end
    end
  end

  // Hold control state under reset; payload needs none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    port_r  <= port_nxt;
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    upd_r   <= upd_nxt;
    on_r    <= on_nxt;
    bfill_r <= bfill_nxt;
    bcrc_r  <= bcrc_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.reply_port    = port_r;
  assign out_ch.reply_byte    = byte_r;
  assign out_ch.last          = last_r;
  assign out_ch.rumble_update = upd_r;
  assign out_ch.rumble_on     = on_r;

  // A read request opens a burst with a fill byte on the next cycle
  a_read_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (take_ok && evt.rd) |=> (valid_r && !last_r && rem_r == REM_W'(DATA_BYTES)))
    else $error("read burst did not start");

  // The closing CRC leaves the burst counter empty
  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> (rem_r == '0))
    else $error("last result while burst still running");

  // Rumble reports ride only on the closing CRC byte
  a_rumble_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (upd_r || on_r)) |-> last_r)
    else $error("rumble flags on a fill byte");

  // Burst counter stays within one block of data
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= REM_W'(DATA_BYTES))
    else $error("burst counter out of range");

endmodule

### rtl/pak_command_responder_crc8.sv
// Controller pak command responder with CRC-8 over pak data.
// A reply is registered: it appears in the output register in the cycle after its byte is taken.
// Input: one byte per cycle while the output register is free and no read burst runs; a
// pak read emits 33 results from the burst counter, holding the input until it is empty.
// Reset (rst_n low, synchronous): no frame open, frame and configuration registers cleared, output empty.
// Depends on pcr_pkg, pcr_if, pcr_cfg_regs, pcr_frame_parser and pcr_reply_gen.
module pak_command_responder_crc8 (
  input  logic      clk,
  input  logic      rst_n,
  pcr_in_if.sink    in_ch,
  pcr_out_if.source out_ch,
  pcr_cfg_if.sink   cfg_ch
);
  import pcr_pkg::*;

  pcr_cfg_t cfg;
  pcr_evt_t evt;
  logic     take_ok;

  // Configuration registers
  pcr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  // Frame tracking and reply requests
  pcr_frame_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take_ok (take_ok),
    .cfg     (cfg),
    .evt     (evt)
  );

  // Result register and read burst
  pcr_reply_gen u_reply (
    .clk     (clk),
    .rst_n   (rst_n),
    .evt     (evt),
    .take_ok (take_ok),
    .out_ch  (out_ch)
  );

endmodule

### verif/pak_reply_tracker.sv
// Reply tracker for the pak command responder: mirrors the frame parser, queues
// the replies each accepted byte should cause and checks every reply transaction.
// Depends on pcr_pkg and the channel interfaces in pcr_if.
module pak_reply_tracker
  import pcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pcr_in_if    in_ch,
  pcr_out_if   out_ch,
  pcr_cfg_if   cfg_ch,
  output int   fail_count,
  output int   replies_owed
);

  typedef struct packed {
    logic [1:0] port;
    logic [7:0] value;
    logic       last;
    logic       rumble_update;
    logic       rumble_on;
  } reply_t;

  reply_t awaited_replies[$];

  // Mirrored registers and frame state
  logic [3:0]       raw_ports;
  logic             rumble_en;
  logic [POS_W-1:0] position;
  logic             in_frame;
  logic [1:0]       owner_port;
  logic [7:0]       command;
  logic [15:0]      pak_addr;
  logic [7:0]       data_crc;
  logic             data0_set;
  int               mismatches = 0;

  // Shift one byte through the CRC-8 a bit at a time, MSB first
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] value);
    logic [7:0] c;
    logic       feedback;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = c[7] ^ value[i];
      c = {c[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic void queue_reply(input logic [7:0] value, input logic last,
                                      input logic upd, input logic on);
    reply_t r;
    r = '{owner_port, value, last, upd, on};
    awaited_replies.push_back(r);
  endfunction

  // Advance the frame by one byte and queue whatever replies it triggers
  function automatic void take_byte(input logic [1:0] port, input logic [7:0] value,
                                    input logic start);
    logic [7:0] fill;
    logic [7:0] crc;
    logic       upd;
    if (start) begin
      in_frame   = 1'b1;
      position   = '0;
      owner_port = port;
      command    = '0;
      pak_addr   = '0;
      data_crc   = '0;
      data0_set  = 1'b0;
    end
    if (in_frame && position <= END_POS) begin
      if (position == POS_CMD) begin
        command = value;
      end else if (position == POS_ADDR_HI) begin
        pak_addr[15:8] = value;
      end else if (position == POS_ADDR_LO) begin
        pak_addr[7:0] = value & ADDR_MASK;
        // a read answers at once with the fill block and its CRC
        if (command == CMD_READ && raw_ports[owner_port]) begin
          fill = (pak_addr >= FILL_LOW && pak_addr < FILL_HIGH) ? FILL_BYTE : ZERO_BYTE;
          crc  = 8'h00;
          for (int k = 0; k < DATA_BYTES; k++) begin
            queue_reply(fill, 1'b0, 1'b0, 1'b0);
            crc = crc8_fold(crc, fill);
          end
          queue_reply(crc, 1'b1, 1'b0, 1'b0);
        end
      end else if (position >= FIRST_DATA_POS) begin
        data_crc = crc8_fold(data_crc, value);
        if (position == FIRST_DATA_POS) begin
          data0_set = (value != 8'h00);
        end
        if (position == END_POS && command == CMD_WRITE && raw_ports[owner_port]) begin
          upd = (pak_addr == RUMBLE_ADDR) && rumble_en;
          queue_reply(data_crc, 1'b1, upd, upd && data0_set);
        end
      end
      position = position + 1'b1;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_reply();
    reply_t want;
    if (awaited_replies.size() == 0) begin
      $error("reply with none awaited: port %0d byte %0h last %0b",
             out_ch.reply_port, out_ch.reply_byte, out_ch.last);
      mismatches++;
    end else begin
      want = awaited_replies.pop_front();
      compare_field("reply_port", 8'(want.port), 8'(out_ch.reply_port));
      compare_field("reply_byte", want.value, out_ch.reply_byte);
      compare_field("last", 8'(want.last), 8'(out_ch.last));
      compare_field("rumble_update", 8'(want.rumble_update), 8'(out_ch.rumble_update));
      compare_field("rumble_on", 8'(want.rumble_on), 8'(out_ch.rumble_on));
    end
  endfunction

  // Track register writes, input bytes and replies at each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      raw_ports  = '0;
      rumble_en  = 1'b0;
      position   = '0;
      in_frame   = 1'b0;
      owner_port = '0;
      command    = '0;
      pak_addr   = '0;
      data_crc   = '0;
      data0_set  = 1'b0;
      awaited_replies.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_RAW_PAK_PORTS) begin
          raw_ports = cfg_ch.data[3:0];
        end else if (cfg_ch.index == REG_RUMBLE_AVAILABLE) begin
          rumble_en = cfg_ch.data[0];
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_byte(in_ch.port, in_ch.frame_byte, in_ch.frame_start);
      end
      if (out_ch.valid && out_ch.ready) begin
        check_reply();
      end
    end
    fail_count   <= mismatches;
    replies_owed <= awaited_replies.size();
  end

endmodule

### verif/pak_command_responder_crc8_test.sv
// Testbench top for the pak command responder: clock, reset, frame and register
// stimulus, reply back-pressure, watchdog and verdict.
// Depends on pcr_pkg, pcr_if, the responder RTL and pak_reply_tracker.
module pak_command_responder_crc8_test;
  import pcr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   replies_owed;
  int   bytes_sent;
  bit   steady_send;

  pcr_in_if  in_ch();
  pcr_out_if out_ch();
  pcr_cfg_if cfg_ch();

  pak_command_responder_crc8 dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pak_reply_tracker reply_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return RUMBLE_ADDR | 16'($urandom_range(0, 31));
    if (r < 60) return FILL_LOW | 16'($urandom_range(0, 16'h0FFF));
    if (r < 70) return FILL_HIGH | 16'($urandom_range(0, 31));
    return 16'($urandom);
  endfunction

  // Offer one byte and hold it until the transaction completes
  task automatic send_byte(input logic [1:0] port, input logic [7:0] value,
                           input logic start);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.port        <= port;
    in_ch.frame_byte  <= value;
    in_ch.frame_start <= start;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Send the first nbytes of a frame; only the first byte carries the real port
  task automatic send_frame(input logic [1:0] port, input logic [7:0] cmd,
                            input logic [15:0] addr, input int nbytes, input bit zero_first);
    logic [7:0] value;
    for (int pos = 0; pos < nbytes; pos++) begin
      if (pos == POS_CMD) begin
        value = cmd;
      end else if (pos == POS_ADDR_HI) begin
        value = addr[15:8];
      end else if (pos == POS_ADDR_LO) begin
        value = addr[7:0];
      end else if (pos == FIRST_DATA_POS) begin
        value = zero_first ? 8'h00 : 8'($urandom_range(1, 255));
      end else begin
        value = 8'($urandom);
      end
      send_byte((pos == 0) ? port : 2'($urandom), value, pos == 0);
    end
  endtask

  // Drop valid and wait until every owed reply has gone out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; spare data bits carry noise
  task automatic configure(input logic [3:0] raw_ports, input logic rumble);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_RAW_PAK_PORTS;
    cfg_ch.data  <= raw_ports;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_RUMBLE_AVAILABLE;
    cfg_ch.data  <= {3'($urandom), rumble};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed frames, some truncated ones and some stray bytes
  task automatic send_random_frame();
    int         r;
    logic [1:0] port;
    r = $urandom_range(0, 99);
    port = 2'($urandom);
    steady_send = ($urandom_range(0, 3) == 0);
    if (r < 35) begin
      send_frame(port, CMD_WRITE, pick_addr(),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(38, 40) : 37,
                 1'($urandom_range(0, 1)));
    end else if (r < 70) begin
      send_frame(port, CMD_READ, pick_addr(), $urandom_range(5, 12), 1'b0);
    end else if (r < 80) begin
      send_frame(port, 8'($urandom), pick_addr(), 5, 1'b0);
    end else if (r < 92) begin
      send_frame(port, ($urandom_range(0, 1) != 0) ? CMD_READ : CMD_WRITE, pick_addr(),
                 $urandom_range(1, 36), 1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(2'($urandom), 8'($urandom), 1'b0);
    end
  endtask

  // Reply side: random open and stalled spans
  initial begin : reply_backpressure
    int span;
    bit accepting;
    out_ch.ready <= 1'b0;
    forever begin
      accepting = ($urandom_range(0, 2) != 0);
      if (accepting) begin
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      end else begin
        span = pick_gap();
      end
      if (span > 0) begin
        @(posedge clk);
        out_ch.ready <= accepting;
        repeat (span - 1) @(posedge clk);
      end
    end
  end

  // End the run when no transaction of any kind happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int phase_start;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.port        <= '0;
    in_ch.frame_byte  <= '0;
    in_ch.frame_start <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_RAW_PAK_PORTS;
    cfg_ch.data       <= '0;
    steady_send = 1'b0;
    bytes_sent  = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // no frame open yet: these bytes go nowhere
    send_byte(2'd3, 8'hFF, 1'b0);
    send_byte(2'd0, 8'h00, 1'b0);
    // raw handling still off after reset
    send_frame(2'd0, CMD_READ, FILL_LOW, 5, 1'b0);
    settle();

    configure(4'hF, 1'b1);
    // read fill at both ends of the fill window and just outside it
    send_frame(2'd1, CMD_READ, FILL_LOW, 5, 1'b0);
    send_frame(2'd2, CMD_READ, 16'h8FFF, 5, 1'b0);
    send_frame(2'd3, CMD_READ, FILL_HIGH, 5, 1'b0);
    send_frame(2'd0, CMD_READ, 16'h7FFF, 5, 1'b0);
    send_frame(2'd1, CMD_READ, 16'h001F, 5, 1'b0);
    // restart mid-frame, then commands that get no reply
    send_frame(2'd2, CMD_READ, FILL_LOW, 3, 1'b0);
    send_frame(2'd3, 8'h00, FILL_LOW, 5, 1'b0);
    send_frame(2'd0, 8'hFF, RUMBLE_ADDR, 5, 1'b0);
    // rumble on with masked address bits and one byte past the end
    steady_send = 1'b1;
    send_frame(2'd1, CMD_WRITE, 16'hC01F, 38, 1'b0);
    steady_send = 1'b0;
    settle();

    // random traffic under several register settings
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       configure(4'b0101, 1'b1);
        1:       configure(4'b1010, 1'b0);
        default: configure(4'b1111, 1'b1);
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS) send_random_frame();
      settle();
    end

    steady_send = 1'b0;
    configure(4'h0, 1'b0);
    send_frame(2'd3, CMD_READ, FILL_LOW, 5, 1'b0);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/pcr_pkg.sv
rtl/pcr_if.sv
rtl/pcr_cfg_regs.sv
rtl/pcr_frame_parser.sv
rtl/pcr_reply_gen.sv
rtl/pak_command_responder_crc8.sv
verif/pak_reply_tracker.sv
verif/pak_command_responder_crc8_test.sv
